/* src/l2t_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l2t_pkg
// Shared types and constants for the raster-to-tile reorder block.
// ----------------------------------------------------------------------------
package l2t_pkg;

    // Pixel-pair word and configuration register widths.
    localparam int DATA_W = 32;
    localparam int CFG_W  = 11;

    // Configuration register indexes.
    localparam logic REG_ROW_PIXELS = 1'b0;
    localparam logic REG_FRAME_ROWS = 1'b1;

    // Register values after reset.
    localparam logic [CFG_W-1:0] ROW_PIXELS_RST = 11'd512;
    localparam logic [CFG_W-1:0] FRAME_ROWS_RST = 11'd240;

    // Beat numbers within a tile: the held even word and the closing odd word.
    localparam logic [2:0] BEAT_HELD = 3'd6;
    localparam logic [2:0] BEAT_LAST = 3'd7;

    // Where a tile beat takes its data from.
    typedef enum logic [1:0] {
        SRC_RAM  = 2'd0,
        SRC_HELD = 2'd1,
        SRC_LAST = 2'd2
    } tile_src_t;

    // One result beat.
    typedef struct packed {
        logic [DATA_W-1:0] texel_word;
        logic              tile_last;
        logic              frame_last;
    } tile_beat_t;

endpackage

/* src/l2t_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l2t_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module l2t_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1536
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port: data appears in the cycle after the read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/linear_to_tiled_rgb565_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_to_tiled_rgb565_top
// Reorders an RGB565 frame from raster order into 4x4-pixel tile order.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one 32-bit beat (two pixels) per handshake in
//   raster order. Rows 0 to 2 of every four-row group are written to a line
//   store; the even word of row 3 is held, and its odd word releases the
//   tile's eight words on the master stream, top row first. m_tlast marks the
//   eighth word of each tile and m_tuser the final word of the frame.
//   Registers (row_pixels, frame_rows) are to be written through the cfg port
//   only while the block is idle; the block itself does not enforce this.
// Throughput and flow:
//   Even row-3 words and dropped rows take one cycle per beat, rows 0 to 2
//   likewise while no tile is being read. The first word of a tile passes
//   through the sequencer, the pending read stage and the output queue after
//   its odd row-3 beat is accepted; the tile then streams at one word per
//   cycle while the receiver takes it. The single output beat per cycle and
//   the single line-store read port limit the row-3 input rate: the next odd
//   word or next store write waits until the tile's eight reads are issued.
// Reset and stalls:
//   aresetn clears the counters and the output queue; the line store needs no
//   clearing. When the receiver stalls, a two-entry output queue fills, the
//   tile reads pause, and the input stalls once it needs the line store.
// ----------------------------------------------------------------------------
module linear_to_tiled_rgb565_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Configuration write port.
    input  logic                         cfg_wr_en,
    input  logic                         cfg_index,
    input  logic [l2t_pkg::CFG_W-1:0]    cfg_data,
    // Input stream.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [l2t_pkg::DATA_W-1:0]   s_tdata,   // [31:0] pixel_pair
    // Output stream.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [l2t_pkg::DATA_W-1:0]   m_tdata,   // [31:0] texel_word
    output logic                         m_tlast,   // tile_last
    output logic                         m_tuser    // [0] frame_last
);

    localparam int ROW_WORDS   = MAX_WIDTH / 2;
    localparam int STORE_DEPTH = 3 * ROW_WORDS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COL_W       = $clog2(ROW_WORDS);
    localparam int WPR_W       = $clog2(ROW_WORDS + 1);
    localparam int RIDX_W      = $clog2(MAX_HEIGHT);
    localparam int ROWS_W      = $clog2(MAX_HEIGHT + 1);
    localparam int WEXT_W      = (l2t_pkg::CFG_W > $clog2(MAX_WIDTH + 1)) ?
                                 l2t_pkg::CFG_W : $clog2(MAX_WIDTH + 1);
    localparam int HEXT_W      = (l2t_pkg::CFG_W > $clog2(MAX_HEIGHT + 1)) ?
                                 l2t_pkg::CFG_W : $clog2(MAX_HEIGHT + 1);

    // ------------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------------
    logic [l2t_pkg::CFG_W-1:0]  row_pixels_reg, row_pixels_next;
    logic [l2t_pkg::CFG_W-1:0]  frame_rows_reg, frame_rows_next;
    logic [COL_W-1:0]           col_reg, col_next;
    logic [RIDX_W-1:0]          row_reg, row_next;
    logic [l2t_pkg::DATA_W-1:0] held_reg, held_next;

    logic                       busy_reg, busy_next;
    logic [2:0]                 k_reg, k_next;
    logic [COL_W-1:0]           base_reg, base_next;
    logic [l2t_pkg::DATA_W-1:0] w6_reg, w6_next;
    logic [l2t_pkg::DATA_W-1:0] w7_reg, w7_next;
    logic                       fl_reg, fl_next;

    logic                       pend_valid_reg, pend_valid_next;
    l2t_pkg::tile_src_t         pend_src_reg, pend_src_next;
    logic                       pend_tl_reg, pend_tl_next;
    logic                       pend_fl_reg, pend_fl_next;

    l2t_pkg::tile_beat_t        fifo_reg [2];
    l2t_pkg::tile_beat_t        fifo_next [2];
    logic                       wr_ptr_reg, wr_ptr_next;
    logic                       rd_ptr_reg, rd_ptr_next;
    logic [1:0]                 cnt_reg, cnt_next;

    logic [WEXT_W-1:0]          w_ext, w_clamp, w_pairs;
    logic [HEXT_W-1:0]          h_ext, h_clamp;
    logic [WPR_W-1:0]           wpr;
    logic [ROWS_W-1:0]          rows, kept;
    logic [COL_W-1:0]           col_eff;
    logic [RIDX_W-1:0]          row_eff;
    logic [WPR_W-1:0]           col_inc;
    logic [ROWS_W-1:0]          row_inc;
    logic                       in_kept, store_wr, hold_even, trigger, frame_end;
    logic [1:0]                 sub;
    logic                       s_acc, pop, issue;
    logic [2:0]                 slots_used, slots_limit;
    logic [ADDR_W-1:0]          row_off, rd_addr, wr_addr;
    logic [l2t_pkg::DATA_W-1:0] ram_q;
    l2t_pkg::tile_beat_t        land_beat, head_beat;

    // ------------------------------------------------------------------------
    // Effective geometry from the registers
    // ------------------------------------------------------------------------
    always_comb begin
        w_ext   = WEXT_W'(row_pixels_reg);
        w_clamp = (w_ext > WEXT_W'(MAX_WIDTH)) ? WEXT_W'(MAX_WIDTH) : w_ext;
        // Words per row: half the width with the low two pixel bits dropped.
        w_pairs = (w_clamp >> 1) & ~WEXT_W'(1);
        wpr     = (w_pairs == '0) ? WPR_W'(2) : w_pairs[WPR_W-1:0];

        h_ext = HEXT_W'(frame_rows_reg);
        if (h_ext > HEXT_W'(MAX_HEIGHT)) begin
            h_clamp = HEXT_W'(MAX_HEIGHT);
        end else if (h_ext < HEXT_W'(4)) begin
            h_clamp = HEXT_W'(4);
        end else begin
            h_clamp = h_ext;
        end
        rows = h_clamp[ROWS_W-1:0];
        kept = rows & ~ROWS_W'(3);
    end

    // ------------------------------------------------------------------------
    // Position of the current input beat and what it does
    // ------------------------------------------------------------------------
    always_comb begin
        // A counter left out of range by a register write restarts at zero.
        col_eff   = (WPR_W'(col_reg) >= wpr) ? '0 : col_reg;
        row_eff   = (ROWS_W'(row_reg) >= rows) ? '0 : row_reg;
        sub       = row_eff[1:0];
        in_kept   = ROWS_W'(row_eff) < kept;
        store_wr  = in_kept && (sub != 2'd3);
        hold_even = in_kept && (sub == 2'd3) && !col_eff[0];
        trigger   = in_kept && (sub == 2'd3) && col_eff[0];
        frame_end = (WPR_W'(col_eff) == wpr - WPR_W'(1)) &&
                    (ROWS_W'(row_eff) == kept - ROWS_W'(1));
        col_inc   = WPR_W'(col_eff) + WPR_W'(1);
        row_inc   = ROWS_W'(row_eff) + ROWS_W'(1);
    end

    // Store writes and new tiles wait while the current tile is still being read.
    assign s_tready = !busy_reg || (!store_wr && !trigger);
    assign s_acc    = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;

    // Line store address for a write: row slot within the group, then column.
    always_comb begin
        case (sub)
            2'd1:    wr_addr = ADDR_W'(ROW_WORDS) + ADDR_W'(col_eff);
            2'd2:    wr_addr = ADDR_W'(2 * ROW_WORDS) + ADDR_W'(col_eff);
            default: wr_addr = ADDR_W'(col_eff);
        endcase
    end

    // ------------------------------------------------------------------------
    // Configuration registers and input counters
    // ------------------------------------------------------------------------
    always_comb begin
        row_pixels_next = row_pixels_reg;
        frame_rows_next = frame_rows_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                l2t_pkg::REG_ROW_PIXELS: row_pixels_next = cfg_data;
                l2t_pkg::REG_FRAME_ROWS: frame_rows_next = cfg_data;
                default:                 row_pixels_next = row_pixels_reg;
            endcase
        end

        col_next  = col_reg;
        row_next  = row_reg;
        held_next = held_reg;
        if (s_acc) begin
            if (col_inc >= wpr) begin
                col_next = '0;
                row_next = (row_inc >= rows) ? '0 : row_inc[RIDX_W-1:0];
            end else begin
                col_next = col_inc[COL_W-1:0];
                row_next = row_eff;
            end
            if (hold_even) begin
                held_next = s_tdata;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tile sequencer: one beat issued per cycle while the queue has room
    // ------------------------------------------------------------------------
    always_comb begin
        slots_used  = 3'(cnt_reg) + 3'(pend_valid_reg);
        slots_limit = 3'd2 + 3'(pop);
        issue       = busy_reg && (slots_used < slots_limit);

        case (k_reg[2:1])
            2'd1:    row_off = ADDR_W'(ROW_WORDS);
            2'd2:    row_off = ADDR_W'(2 * ROW_WORDS);
            default: row_off = '0;
        endcase
        rd_addr = row_off + ADDR_W'(base_reg) + ADDR_W'(k_reg[0]);

        busy_next = busy_reg;
        k_next    = k_reg;
        base_next = base_reg;
        w6_next   = w6_reg;
        w7_next   = w7_reg;
        fl_next   = fl_reg;
        if (issue) begin
            k_next = k_reg + 3'd1;
            if (k_reg == l2t_pkg::BEAT_LAST) begin
                busy_next = 1'b0;
            end
        end
        // A new tile is only accepted when the sequencer is free.
        if (s_acc && trigger) begin
            busy_next = 1'b1;
            k_next    = '0;
            base_next = {col_eff[COL_W-1:1], 1'b0};
            w6_next   = held_reg;
            w7_next   = s_tdata;
            fl_next   = frame_end;
        end

        pend_valid_next = issue;
        pend_src_next   = pend_src_reg;
        pend_tl_next    = pend_tl_reg;
        pend_fl_next    = pend_fl_reg;
        if (issue) begin
            pend_tl_next = (k_reg == l2t_pkg::BEAT_LAST);
            pend_fl_next = (k_reg == l2t_pkg::BEAT_LAST) && fl_reg;
            if (k_reg == l2t_pkg::BEAT_LAST) begin
                pend_src_next = l2t_pkg::SRC_LAST;
            end else if (k_reg == l2t_pkg::BEAT_HELD) begin
                pend_src_next = l2t_pkg::SRC_HELD;
            end else begin
                pend_src_next = l2t_pkg::SRC_RAM;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output queue: two entries decouple the reads from the receiver
    // ------------------------------------------------------------------------
    always_comb begin
        case (pend_src_reg)
            l2t_pkg::SRC_HELD: land_beat.texel_word = w6_reg;
            l2t_pkg::SRC_LAST: land_beat.texel_word = w7_reg;
            default:           land_beat.texel_word = ram_q;
        endcase
        land_beat.tile_last  = pend_tl_reg;
        land_beat.frame_last = pend_fl_reg;

        fifo_next[0] = fifo_reg[0];
        fifo_next[1] = fifo_reg[1];
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        if (pend_valid_reg) begin
            fifo_next[wr_ptr_reg] = land_beat;
            wr_ptr_next           = !wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        cnt_next = cnt_reg + 2'(pend_valid_reg) - 2'(pop);
    end

    assign head_beat = fifo_reg[rd_ptr_reg];
    assign m_tvalid  = (cnt_reg != 2'd0);
    assign m_tdata   = head_beat.texel_word;
    assign m_tlast   = head_beat.tile_last;
    assign m_tuser   = head_beat.frame_last;

    // ------------------------------------------------------------------------
    // Line store
    // ------------------------------------------------------------------------
    l2t_ram #(
        .WIDTH (l2t_pkg::DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_row_store (
        .aclk    (aclk),
        .wr_en   (s_acc && store_wr),
        .wr_addr (wr_addr),
        .wr_data (s_tdata),
        .rd_en   (issue),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_pixels_reg <= l2t_pkg::ROW_PIXELS_RST;
            frame_rows_reg <= l2t_pkg::FRAME_ROWS_RST;
            col_reg        <= '0;
            row_reg        <= '0;
            busy_reg       <= 1'b0;
            k_reg          <= '0;
            pend_valid_reg <= 1'b0;
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            row_pixels_reg <= row_pixels_next;
            frame_rows_reg <= frame_rows_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            busy_reg       <= busy_next;
            k_reg          <= k_next;
            pend_valid_reg <= pend_valid_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            cnt_reg        <= cnt_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        held_reg     <= held_next;
        base_reg     <= base_next;
        w6_reg       <= w6_next;
        w7_reg       <= w7_next;
        fl_reg       <= fl_next;
        pend_src_reg <= pend_src_next;
        pend_tl_reg  <= pend_tl_next;
        pend_fl_reg  <= pend_fl_next;
        fifo_reg[0]  <= fifo_next[0];
        fifo_reg[1]  <= fifo_next[1];
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // The line store is never written while a tile is still being read from it.
    a_no_write_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_acc && store_wr && busy_reg))
        else $error("line store written during tile read-out");

    // The output queue never overflows.
    a_queue_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pend_valid_reg && (cnt_reg == 2'd2) && !pop))
        else $error("output queue overflow");

    // An accepted odd row-3 beat starts a tile at its first beat.
    a_tile_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && trigger) |=> (busy_reg && (k_reg == 3'd0)))
        else $error("tile did not start after its closing beat");

    // The frame marker only ever rides on a tile's last word.
    a_frame_on_tile_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("frame end without tile end");

    // The queue count stays within its two entries.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("output queue count out of range");

endmodule
